[rtl/srcm_pkg.sv]
`default_nettype none

package srcm_pkg;

  // Configuration register indexes.
  localparam logic [2:0] CFG_PAIR0      = 3'd0;
  localparam logic [2:0] CFG_PAIR1      = 3'd1;
  localparam logic [2:0] CFG_PAIR2      = 3'd2;
  localparam logic [2:0] CFG_PAIR3      = 3'd3;
  localparam logic [2:0] CFG_TABLE_SIZE = 3'd4;
  localparam logic [2:0] CFG_RANGE_MIN  = 3'd5;
  localparam logic [2:0] CFG_RANGE_MAX  = 3'd6;

  // Input item kinds.
  localparam logic MODE_RANGE = 1'b0;
  localparam logic MODE_COLOR = 1'b1;

  // Reset contents of the color table: entry 0 white, entry 1 opaque red.
  localparam logic [63:0] PAIR0_RESET = 64'hFF0000FF_FFFFFFFF;

  // Quotient bits produced by the divider: 4 integer bits, 8 fraction bits.
  localparam int QUOT_BITS = 12;

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b00_0000_0001,
    ST_SETUP   = 10'b00_0000_0010,
    ST_SCALE   = 10'b00_0000_0100,
    ST_CHECK   = 10'b00_0000_1000,
    ST_DIV     = 10'b00_0001_0000,
    ST_FETCH   = 10'b00_0010_0000,
    ST_LOAD_LO = 10'b00_0100_0000,
    ST_LOAD_HI = 10'b00_1000_0000,
    ST_BLEND   = 10'b01_0000_0000,
    ST_DONE    = 10'b10_0000_0000
  } state_t;

endpackage

`default_nettype wire

[rtl/scalar_range_colormap_core.sv]
`default_nettype none

// Scalar-to-color mapper. Each point's Q16.16 scalar is placed in a range,
// scaled to a position in a color table of 2..TABLE_DEPTH entries and turned
// into an RGBA color by blending the two neighboring entries.
// Input channel (s_*): s_tdata carries the scalar, s_tuser the item kind and
// the first-of-pass flag. A range-pass beat (mode 0) folds its value into the
// running minimum and maximum in the cycle it is taken and yields nothing.
// A color-pass beat (mode 1) yields exactly one beat on the output channel
// (m_*): RGBA in m_tdata and the flat-range flag in m_tuser.
// Configuration channel (cfg_*): ready outside reset; the user must make
// writes only while idle; the block itself does not enforce this. A color
// beat goes through the divider when the quotient has to be computed and
// skips it when the position is known at once (flat range, value at or
// below the range start, or clearly past its end). The divider delivers
// one quotient bit per cycle over 12 bits; the blend runs one color
// channel per cycle after it. A range-pass beat leaves the block idle.
// The finished color waits in an output register, so the block takes the
// next beat while the receiver stalls; only a second finished color waits
// for the first one to leave. Reset (rst, synchronous) loads the register
// defaults and clears the running range and the handshake state.
module scalar_range_colormap_core #(
  parameter int TABLE_DEPTH     = 8,
  parameter int VALUE_FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,    // [31:0] value
  input  wire logic [1:0]  s_tuser,    // [0] mode, [1] first
  // Output stream.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,    // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha
  output logic             m_tuser,    // [0] flat_range
  // Configuration writes.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  import srcm_pkg::*;

  // Smallest span, in Q format units, that still counts as a fixed range.
  localparam logic [32:0] RangeEps = 33'(((1 << VALUE_FRAC_BITS) + 999) / 1000);
  localparam logic [3:0]  MaxSize  = 4'(TABLE_DEPTH);

  // Configuration registers.
  logic [63:0] color_pair [4];
  logic [3:0]  table_size;
  logic [31:0] range_min;
  logic [31:0] range_max;

  // Running range state.
  logic [31:0] running_min;
  logic [31:0] running_max;
  logic        range_seen;

  // Derived from configuration, refreshed every cycle.
  logic        fixed_rng;
  logic [2:0]  nm1;

  state_t      state;
  logic [31:0] value_q;
  logic        flat;
  logic [32:0] offs;
  logic [32:0] den;
  logic signed [36:0] num;
  logic [31:0] den_mag;
  logic [35:0] rem;
  logic [QUOT_BITS-1:0] quot;
  logic [3:0]  cnt;
  logic [2:0]  lo_idx;
  logic [2:0]  up_idx;
  logic [7:0]  frac;
  logic [31:0] cl;
  logic [31:0] cu;
  logic [31:0] color;

  // Combinational helpers.
  logic        s_acc;
  logic [32:0] diff;
  logic [32:0] abs_diff;
  logic [3:0]  n_sat;
  logic [31:0] lo_sel;
  logic [31:0] hi_sel;
  logic [32:0] noffs;
  logic [32:0] nden;
  logic signed [36:0] prod;
  logic        num_pos;
  logic        ovf;
  logic [35:0] dsh;
  logic        ge;
  logic [35:0] rem_next;
  logic [10:0] top;
  logic [QUOT_BITS-1:0] qs;
  logic [2:0]  lower;
  logic [2:0]  upper;
  logic [2:0]  rd_idx;
  logic [31:0] rd_entry;
  logic [7:0]  ch_a;
  logic [7:0]  ch_b;
  logic signed [8:0]  ch_d;
  logic signed [17:0] ch_prod;
  logic signed [17:0] ch_sum;

  assign cfg_ready = !rst;
  assign s_tready  = !rst && (state == ST_IDLE);
  assign s_acc     = s_tvalid && s_tready;

  // Span of the fixed range and the clamped table size.
  always_comb begin
    diff     = {range_max[31], range_max} - {range_min[31], range_min};
    abs_diff = diff[32] ? (33'd0 - diff) : diff;
    if (table_size < 4'd2) begin
      n_sat = 4'd2;
    end else if (table_size > MaxSize) begin
      n_sat = MaxSize;
    end else begin
      n_sat = table_size;
    end
  end

  always_ff @(posedge clk) begin
    fixed_rng <= (abs_diff >= RangeEps);
    nm1       <= 3'(n_sat - 4'd1);
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      color_pair[0] <= PAIR0_RESET;
      color_pair[1] <= '0;
      color_pair[2] <= '0;
      color_pair[3] <= '0;
      table_size    <= 4'd2;
      range_min     <= 32'hFFFF_0000;
      range_max     <= 32'hFFFF_0000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PAIR0:      color_pair[0] <= cfg_data;
        CFG_PAIR1:      color_pair[1] <= cfg_data;
        CFG_PAIR2:      color_pair[2] <= cfg_data;
        CFG_PAIR3:      color_pair[3] <= cfg_data;
        CFG_TABLE_SIZE: table_size    <= cfg_data[3:0];
        CFG_RANGE_MIN:  range_min     <= cfg_data[31:0];
        CFG_RANGE_MAX:  range_max     <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Range pass: fold the value into the running minimum and maximum.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_min <= 32'h7FFF_FFFF;
      running_max <= 32'h8000_0000;
      range_seen  <= 1'b0;
    end else if (s_acc && (s_tuser[0] == MODE_RANGE)) begin
      range_seen <= 1'b1;
      if (s_tuser[1]) begin
        running_min <= s_tdata;
        running_max <= s_tdata;
      end else begin
        if ($signed(s_tdata) < $signed(running_min)) begin
          running_min <= s_tdata;
        end
        if ($signed(s_tdata) > $signed(running_max)) begin
          running_max <= s_tdata;
        end
      end
    end
  end

  // Datapath helpers for the color pass.
  always_comb begin
    lo_sel   = fixed_rng ? range_min : running_min;
    hi_sel   = fixed_rng ? range_max : running_max;
    // A downward range flips both numerator and span.
    noffs    = den[32] ? (33'd0 - offs) : offs;
    nden     = den[32] ? (33'd0 - den) : den;
    prod     = 37'($signed(noffs)) * 37'($signed({1'b0, nm1}));
    num_pos  = !num[36] && (num != '0);
    // num at or beyond 16 spans means the position is past any table end.
    ovf      = num[35:0] >= {den_mag, 4'h0};
    dsh      = {1'b0, den_mag, 3'b000};
    ge       = rem >= dsh;
    rem_next = ge ? ((rem - dsh) << 1) : (rem << 1);
    top      = {nm1, 8'h00};
    qs       = (quot > {1'b0, top}) ? {1'b0, top} : quot;
    lower    = qs[10:8];
    upper    = (lower == nm1) ? nm1 : (lower + 3'd1);
    rd_idx   = (state == ST_LOAD_HI) ? up_idx : lo_idx;
    rd_entry = rd_idx[0] ? color_pair[rd_idx[2:1]][63:32]
                         : color_pair[rd_idx[2:1]][31:0];
    // One channel: a + (b - a) * f / 256, rounded.
    ch_a     = cl[31:24];
    ch_b     = cu[31:24];
    ch_d     = $signed({1'b0, ch_b}) - $signed({1'b0, ch_a});
    ch_prod  = ch_d * $signed({1'b0, frac});
    ch_sum   = $signed({2'b00, ch_a, 8'h80}) + ch_prod;
  end

  // Color pass sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // A beat leaving in the cycle a new color is loaded is handled in ST_DONE.
      if (m_tvalid && m_tready && (state != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_acc && (s_tuser[0] == MODE_COLOR)) begin
            value_q <= s_tdata;
            state   <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          flat  <= !fixed_rng && (!range_seen || (running_max == running_min));
          offs  <= {value_q[31], value_q} - {lo_sel[31], lo_sel};
          den   <= {hi_sel[31], hi_sel} - {lo_sel[31], lo_sel};
          state <= ST_SCALE;
        end
        ST_SCALE: begin
          num     <= prod;
          den_mag <= nden[31:0];
          state   <= ST_CHECK;
        end
        ST_CHECK: begin
          rem <= num[35:0];
          cnt <= 4'(QUOT_BITS - 1);
          if (flat || !num_pos) begin
            quot  <= '0;
            state <= ST_FETCH;
          end else if (ovf) begin
            quot  <= '1;
            state <= ST_FETCH;
          end else begin
            quot  <= '0;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem  <= rem_next;
          quot <= {quot[QUOT_BITS-2:0], ge};
          cnt  <= cnt - 4'd1;
          if (cnt == 4'd0) begin
            state <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          lo_idx <= lower;
          up_idx <= upper;
          frac   <= qs[7:0];
          state  <= ST_LOAD_LO;
        end
        ST_LOAD_LO: begin
          cl    <= rd_entry;
          state <= ST_LOAD_HI;
        end
        ST_LOAD_HI: begin
          cu    <= rd_entry;
          cnt   <= 4'd3;
          state <= ST_BLEND;
        end
        ST_BLEND: begin
          // Red first; it ends up in the low byte after four shifts.
          color <= {ch_sum[15:8], color[31:8]};
          cl    <= {cl[23:0], 8'h00};
          cu    <= {cu[23:0], 8'h00};
          cnt   <= cnt - 4'd1;
          if (cnt == 4'd0) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= color;
            m_tuser  <= flat;
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
